// ----- src/cfm_pkg.sv -----
`default_nettype none
package cfm_pkg;

  localparam int unsigned MaxConesDefault = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DistW = 34;
  localparam int unsigned CountW = 7;
  localparam int unsigned VerdictW = 2;

  typedef enum logic [1:0] {
    CfgCriticalRange = 2'd0,
    CfgMatchDistance = 2'd1,
    CfgMinPrevious = 2'd2
  } cfg_idx_e;

  typedef enum logic [VerdictW-1:0] {
    VerdictMatched = 2'd0,
    VerdictTooFew = 2'd1,
    VerdictUnmatched = 2'd2,
    VerdictMoreInZone = 2'd3
  } verdict_e;

  // controller to datapath
  typedef struct packed {
    logic load_cone;
    logic start_old;
    logic next_old;
    logic step_new;
    logic finish;
  } cfm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_few;
    logic old_done;
    logic new_done;
    logic old_in_zone;
  } cfm_sts_t;

  function automatic logic [DistW-1:0] sq_sum(input logic signed [CoordW:0] dx,
                                             input logic signed [CoordW:0] dy);
    logic [2*CoordW+1:0] px;
    logic [2*CoordW+1:0] py;
    begin
      px = 34'(dx * dx);
      py = 34'(dy * dy);
      sq_sum = px + py;
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/cfm_ctrl.sv -----
`default_nettype none
module cfm_ctrl
  import cfm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     frame_last_i,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cfm_cmd_t      cmd_o,
  input  wire cfm_sts_t sts_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StOld = 3'd1;
  localparam logic [2:0] StZone = 3'd2;
  localparam logic [2:0] StNew = 3'd3;
  localparam logic [2:0] StCheck = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       fire;

  assign in_ready  = (state_q == StIdle) && !out_valid_q;
  assign out_valid = out_valid_q;
  assign fire      = in_valid && in_ready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (fire) begin
          cmd_o.load_cone = 1'b1;
          if (frame_last_i) state_d = StOld;
        end
      end
      StOld: begin
        cmd_o.start_old = 1'b1;
        state_d = StZone;
      end
      StZone: begin
        priority if (sts_i.too_few || sts_i.old_done) begin
          state_d = StDone;
        end else if (sts_i.old_in_zone) begin
          state_d = StNew;
        end else begin
          cmd_o.next_old = 1'b1;
        end
      end
      StNew: begin
        if (sts_i.new_done) state_d = StCheck;
        else cmd_o.step_new = 1'b1;
      end
      StCheck: begin
        cmd_o.next_old = 1'b1;
        state_d = StZone;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid) else $error("no result after search");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("result lost");

endmodule
`default_nettype wire

// ----- src/cfm_datapath.sv -----
`default_nettype none
module cfm_datapath
  import cfm_pkg::*;
#(
  parameter int unsigned MaxCones = MaxConesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_idx,
  input  wire logic [DistW-1:0]         cfg_wdata,
  input  wire logic signed [CoordW-1:0] cone_x_i,
  input  wire logic signed [CoordW-1:0] cone_y_i,
  input  wire logic                     cone_present_i,
  input  wire cfm_cmd_t                 cmd_i,
  output cfm_sts_t                      sts_o,
  output logic                          matched_o,
  output logic [VerdictW-1:0]           verdict_o,
  output logic [CountW-1:0]             old_in_zone_o,
  output logic [CountW-1:0]             new_in_zone_o,
  output logic                          frame_overflow_o
);

  localparam int unsigned AW = $clog2(MaxCones);
  localparam int unsigned CW = $clog2(MaxCones + 1);
  localparam logic [CW-1:0] CapC = CW'(MaxCones);

  logic [2*CoordW-1:0] mem_q [2*(2**AW)];

  logic [DistW-1:0] crit_q, mdist_q;
  logic [CountW-1:0] minprev_q;
  logic bank_q;
  logic [CW-1:0] prev_cnt_q, inc_cnt_q, i_q, j_q;
  logic [CountW-1:0] inc_zone_q, old_zone_q;
  logic ovf_q, found_q, fail_q;
  logic [DistW-1:0] best_q;
  logic [2*CoordW-1:0] old_q, rd_q;
  logic rd_ok_q, old_ok_q;

  logic [DistW-1:0] in_d2, old_d2, pair_d2;
  logic load_ok;

  assign load_ok = cmd_i.load_cone && cone_present_i && (inc_cnt_q < CapC);
  assign in_d2 = sq_sum(17'(cone_x_i), 17'(cone_y_i));
  assign old_d2 = sq_sum(17'($signed(old_q[15:0])), 17'($signed(old_q[31:16])));
  assign pair_d2 = sq_sum(17'($signed(old_q[15:0])) - 17'($signed(rd_q[15:0])),
                          17'($signed(old_q[31:16])) - 17'($signed(rd_q[31:16])));

  // old cone read by i_q, new cone by j_q; one port, registered
  always_ff @(posedge clk_i) begin
    if (load_ok) mem_q[{~bank_q, inc_cnt_q[AW-1:0]}] <= {cone_y_i, cone_x_i};
    if (cmd_i.start_old || cmd_i.next_old)
      old_q <= mem_q[{bank_q, (cmd_i.start_old ? AW'(0) : AW'(i_q + 1'b1))}];
    else
      rd_q <= mem_q[{~bank_q, j_q[AW-1:0]}];
  end

  assign sts_o.too_few = prev_cnt_q < CW'(minprev_q) ||
                         (CW < CountW && minprev_q > CountW'(prev_cnt_q));
  assign sts_o.old_done = fail_q || (i_q >= prev_cnt_q);
  assign sts_o.old_in_zone = old_d2 < crit_q;
  assign sts_o.new_done = rd_ok_q && (j_q >= inc_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= DistW'(6553600); mdist_q <= DistW'(65536); minprev_q <= CountW'(4);
      bank_q <= 1'b0; prev_cnt_q <= '0; inc_cnt_q <= '0; inc_zone_q <= '0;
      ovf_q <= 1'b0; i_q <= '0; j_q <= '0; old_zone_q <= '0; found_q <= 1'b0;
      fail_q <= 1'b0; best_q <= '0; rd_ok_q <= 1'b0; old_ok_q <= 1'b0;
      matched_o <= 1'b0; verdict_o <= VerdictMatched; old_in_zone_o <= '0;
      new_in_zone_o <= '0; frame_overflow_o <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CfgCriticalRange: crit_q <= cfg_wdata;
          CfgMatchDistance: mdist_q <= cfg_wdata;
          CfgMinPrevious: minprev_q <= cfg_wdata[CountW-1:0];
          default: ;
        endcase
      end
      if (load_ok) begin
        inc_cnt_q <= inc_cnt_q + 1'b1;
        if (in_d2 < crit_q) inc_zone_q <= inc_zone_q + 1'b1;
      end else if (cmd_i.load_cone && cone_present_i) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.start_old) begin
        i_q <= '0; old_zone_q <= '0; fail_q <= 1'b0;
        j_q <= '0; rd_ok_q <= 1'b0; found_q <= 1'b0; old_ok_q <= 1'b0;
      end
      if (cmd_i.step_new) begin
        // first step counts the zone cone and waits for data
        if (!old_ok_q) begin
          old_ok_q <= 1'b1;
          old_zone_q <= old_zone_q + 1'b1;
        end
        if (rd_ok_q) begin
          if (!found_q || pair_d2 < best_q) best_q <= pair_d2;
          found_q <= 1'b1;
          j_q <= j_q + 1'b1;
          rd_ok_q <= 1'b0;
        end else begin
          rd_ok_q <= 1'b1;
        end
      end
      if (cmd_i.next_old) begin
        if (old_ok_q && (!found_q || best_q > mdist_q)) fail_q <= 1'b1;
        i_q <= i_q + 1'b1;
        j_q <= '0; rd_ok_q <= 1'b0; found_q <= 1'b0; old_ok_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        priority if (sts_o.too_few) begin
          verdict_o <= VerdictTooFew; old_in_zone_o <= '0;
        end else if (fail_q) begin
          verdict_o <= VerdictUnmatched; old_in_zone_o <= old_zone_q;
        end else if (old_zone_q < inc_zone_q) begin
          verdict_o <= VerdictMoreInZone; old_in_zone_o <= old_zone_q;
        end else begin
          verdict_o <= VerdictMatched; old_in_zone_o <= old_zone_q;
        end
        matched_o <= !sts_o.too_few && !fail_q && !(old_zone_q < inc_zone_q);
        new_in_zone_o <= inc_zone_q;
        frame_overflow_o <= ovf_q;
        bank_q <= ~bank_q;
        prev_cnt_q <= inc_cnt_q;
        inc_cnt_q <= '0; inc_zone_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_cnt_q <= CapC) else $error("count beyond capacity");
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> bank_q != $past(bank_q)) else $error("bank not swapped");
  a_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.finish) |-> (matched_o == (verdict_o == VerdictMatched)))
    else $error("matched disagrees");

endmodule
`default_nettype wire

// ----- src/cone_frame_matcher.sv -----
`default_nettype none
// Cones load one per transaction into one bank of a two-bank store; the other
// bank holds the previous frame. The last transaction of a frame starts a search
// on one store read port that pairs each of the previous cones in the zone with
// all new cones (stopping early when an old cone is left unmatched), after which
// one verdict is given and the banks swap.
// No input is taken during the search or while a verdict waits.
module cone_frame_matcher
  import cfm_pkg::*;
#(
  parameter int unsigned MaxCones = MaxConesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_idx,
  input  wire logic [DistW-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [CoordW-1:0] cone_x_i,
  input  wire logic signed [CoordW-1:0] cone_y_i,
  input  wire logic                     cone_present_i,
  input  wire logic                     frame_last_i,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          matched_o,
  output logic [VerdictW-1:0]           verdict_o,
  output logic [CountW-1:0]             old_in_zone_o,
  output logic [CountW-1:0]             new_in_zone_o,
  output logic                          frame_overflow_o
);

  cfm_cmd_t cmd;
  cfm_sts_t sts;

  cfm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .frame_last_i,
    .out_valid, .out_ready, .cmd_o(cmd), .sts_i(sts)
  );

  cfm_datapath #(.MaxCones(MaxCones)) u_dp (
    .clk_i, .rst_ni, .cfg_we, .cfg_idx, .cfg_wdata, .cone_x_i, .cone_y_i,
    .cone_present_i, .cmd_i(cmd), .sts_o(sts), .matched_o, .verdict_o,
    .old_in_zone_o, .new_in_zone_o, .frame_overflow_o
  );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;
  import cfm_pkg::*;

  localparam int unsigned Cap = 64;
  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned StallLimit = 100000;

  typedef struct {
    logic          matched;
    verdict_e      verdict;
    logic [6:0]    old_zone;
    logic [6:0]    new_zone;
    logic          overflow;
  } verdict_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [1:0]               cfg_idx;
  logic [DistW-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [CoordW-1:0] cone_x;
  logic signed [CoordW-1:0] cone_y;
  logic                     cone_present;
  logic                     frame_last;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     matched;
  logic [VerdictW-1:0]      verdict;
  logic [CountW-1:0]        old_in_zone;
  logic [CountW-1:0]        new_in_zone;
  logic                     frame_overflow;

  cone_frame_matcher u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cone_x_i         (cone_x),
    .cone_y_i         (cone_y),
    .cone_present_i   (cone_present),
    .frame_last_i     (frame_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched_o        (matched),
    .verdict_o        (verdict),
    .old_in_zone_o    (old_in_zone),
    .new_in_zone_o    (new_in_zone),
    .frame_overflow_o (frame_overflow)
  );

  // predictor state
  logic [DistW-1:0] zone_sq;
  logic [DistW-1:0] match_sq;
  logic [6:0]       min_prev;
  int               old_x [Cap];
  int               old_y [Cap];
  int               new_x [Cap];
  int               new_y [Cap];
  int unsigned      old_count;
  int unsigned      new_count;
  int unsigned      new_zone_count;
  logic             dropped;

  verdict_t    verdict_q [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned quiet_cycles;
  logic        moved;

  // last frame sent, used to build the next one
  int          last_x [80];
  int          last_y [80];
  int unsigned last_n;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned dist_sq(longint dx, longint dy);
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic logic near_car(int x, int y);
    return dist_sq(x, y) < longint'(zone_sq);
  endfunction

  function automatic void predict_frame(int x, int y, logic present, logic last);
    verdict_t        r;
    int unsigned     zone_old;
    int unsigned     i;
    int unsigned     j;
    logic            found;
    longint unsigned best;
    longint unsigned d;
    if (present) begin
      if (new_count < Cap) begin
        new_x[new_count] = x;
        new_y[new_count] = y;
        new_count++;
        if (near_car(x, y)) new_zone_count++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (!last) return;
    r.verdict = VerdictMatched;
    zone_old = 0;
    if (old_count < min_prev) begin
      r.verdict = VerdictTooFew;
    end else begin
      i = 0;
      while (i < old_count && r.verdict == VerdictMatched) begin
        if (near_car(old_x[i], old_y[i])) begin
          zone_old++;
          found = 1'b0;
          best = 0;
          for (j = 0; j < new_count; j++) begin
            d = dist_sq(old_x[i] - new_x[j], old_y[i] - new_y[j]);
            if (!found || d < best) begin
              best = d;
              found = 1'b1;
            end
          end
          if (!found || best > longint'(match_sq)) r.verdict = VerdictUnmatched;
        end
        i++;
      end
      if (r.verdict == VerdictMatched && zone_old < new_zone_count)
        r.verdict = VerdictMoreInZone;
    end
    r.matched = (r.verdict == VerdictMatched);
    r.old_zone = 7'(zone_old);
    r.new_zone = 7'(new_zone_count);
    r.overflow = dropped;
    verdict_q.insert(verdict_q.size(), r);
    for (i = 0; i < new_count; i++) begin
      old_x[i] = new_x[i];
      old_y[i] = new_y[i];
    end
    old_count = new_count;
    new_count = 0;
    new_zone_count = 0;
    dropped = 1'b0;
  endfunction

  task automatic send_item(int x, int y, logic present, logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cone_x <= 16'(x);
    cone_y <= 16'(y);
    cone_present <= present;
    frame_last <= last;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    predict_frame(int'(signed'(16'(x))), int'(signed'(16'(y))), present, last);
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DistW-1:0] value);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgCriticalRange: zone_sq = value;
      CfgMatchDistance: match_sq = value;
      default: min_prev = value[6:0];
    endcase
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // builds and sends one frame, mostly a jittered copy of the previous one
  task automatic send_frame();
    int          kind;
    int unsigned n;
    int unsigned i;
    int unsigned k;
    int          t;
    logic        marker_end;
    kind = $urandom_range(0, 99);
    if (kind < 55 && last_n > 0) begin
      n = last_n;
      for (i = 0; i < n; i++) begin
        last_x[i] = clamp16(last_x[i] + $urandom_range(0, 600) - 300);
        last_y[i] = clamp16(last_y[i] + $urandom_range(0, 600) - 300);
      end
      for (i = 0; i < n; i++) begin
        k = $urandom_range(0, n - 1);
        t = last_x[i]; last_x[i] = last_x[k]; last_x[k] = t;
        t = last_y[i]; last_y[i] = last_y[k]; last_y[k] = t;
      end
      if ($urandom_range(0, 9) == 0 && n > 1) n--;
      else if ($urandom_range(0, 9) == 0 && n < 79) begin
        last_x[n] = $urandom_range(0, 6000) - 3000;
        last_y[n] = $urandom_range(0, 6000) - 3000;
        n++;
      end
    end else begin
      if (kind < 75) n = $urandom_range(0, 12);
      else if (kind < 85) n = $urandom_range(0, 8);
      else if (kind < 89) n = $urandom_range(60, 72);
      else n = $urandom_range(3, 20);
      for (i = 0; i < n; i++) begin
        if (kind >= 75 && kind < 85) begin
          last_x[i] = int'(signed'(16'($urandom)));
          last_y[i] = int'(signed'(16'($urandom)));
        end else begin
          last_x[i] = $urandom_range(0, 8000) - 4000;
          last_y[i] = $urandom_range(0, 8000) - 4000;
        end
      end
    end
    last_n = n;
    marker_end = (n == 0) || ($urandom_range(0, 9) < 3);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_item(int'(signed'(16'($urandom))), int'(signed'(16'($urandom))), 1'b0, 1'b0);
      send_item(last_x[i], last_y[i], 1'b1, !marker_end && i == n - 1);
    end
    if (marker_end)
      send_item(int'(signed'(16'($urandom))), int'(signed'(16'($urandom))), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_item(-32768, -32768, 1'b1, 1'b0);
    send_item(32767, 32767, 1'b1, 1'b0);
    send_item(0, 0, 1'b1, 1'b0);
    send_item(100, -100, 1'b1, 1'b1);
    send_item(-1, 1, 1'b0, 1'b0);
    send_item(-32768, -32768, 1'b1, 1'b0);
    send_item(32767, 32767, 1'b1, 1'b0);
    send_item(0, 0, 1'b1, 1'b0);
    send_item(100, -100, 1'b1, 1'b0);
    send_item(0, 0, 1'b0, 1'b1);
    // empty new frame leaves old zone cones unmatched
    send_item(0, 0, 1'b0, 1'b1);
    write_reg(CfgMinPrevious, 0);
    send_item(5, 5, 1'b1, 1'b1);
    send_item(300, 0, 1'b1, 1'b0);
    send_item(-200, 0, 1'b1, 1'b1);
    write_reg(CfgCriticalRange, {DistW{1'b1}});
    write_reg(CfgMatchDistance, {DistW{1'b1}});
    send_item(-32768, 32767, 1'b1, 1'b0);
    send_item(32767, -32768, 1'b1, 1'b1);
    write_reg(CfgCriticalRange, 0);
    write_reg(CfgMatchDistance, 0);
    write_reg(CfgMinPrevious, 64);
    send_item(1, 1, 1'b1, 1'b1);
  endtask

  task automatic test_random();
    int unsigned mode;
    int unsigned setting;
    int unsigned frames;
    setting = 0;
    for (mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 69 : 0;
      rx_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 20 : 0;
      while (items_sent < ItemTarget * (mode + 1) / 3) begin
        case (setting % 4)
          0: begin
            write_reg(CfgCriticalRange, 6553600);
            write_reg(CfgMatchDistance, 65536);
            write_reg(CfgMinPrevious, 4);
          end
          1: begin
            write_reg(CfgCriticalRange, {DistW{1'b1}});
            write_reg(CfgMatchDistance, {DistW{1'b1}});
            write_reg(CfgMinPrevious, 0);
          end
          2: begin
            write_reg(CfgCriticalRange, 0);
            write_reg(CfgMatchDistance, 0);
            write_reg(CfgMinPrevious, 64);
          end
          default: begin
            write_reg(CfgCriticalRange, {2'($urandom_range(0, 3)), 32'($urandom)} >>
                      $urandom_range(0, 12));
            write_reg(CfgMatchDistance, $urandom_range(0, 200000));
            write_reg(CfgMinPrevious, $urandom_range(0, 10));
          end
        endcase
        setting++;
        frames = (setting % 4 == 3) ? 10 : 25;
        repeat (frames)
          if (items_sent < ItemTarget * (mode + 1) / 3) send_frame();
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(negedge clk_i) begin
    verdict_t e;
    moved = (in_valid && in_ready) || (out_valid && out_ready);
    if (rst_ni && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict transaction with nothing expected");
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (matched !== e.matched) begin
          $error("matched exp %0d got %0d", e.matched, matched);
          errors++;
        end
        if (verdict !== e.verdict) begin
          $error("verdict exp %0d got %0d", e.verdict, verdict);
          errors++;
        end
        if (old_in_zone !== e.old_zone) begin
          $error("old_in_zone exp %0d got %0d", e.old_zone, old_in_zone);
          errors++;
        end
        if (new_in_zone !== e.new_zone) begin
          $error("new_in_zone exp %0d got %0d", e.new_zone, new_in_zone);
          errors++;
        end
        if (frame_overflow !== e.overflow) begin
          $error("frame_overflow exp %0d got %0d", e.overflow, frame_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (moved || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    quiet_cycles = 0;
    moved = 1'b0;
    last_n = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    zone_sq = 6553600;
    match_sq = 65536;
    min_prev = 4;
    old_count = 0;
    new_count = 0;
    new_zone_count = 0;
    dropped = 1'b0;
    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CfgCriticalRange;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    cone_x <= '0;
    cone_y <= '0;
    cone_present <= 1'b0;
    frame_last <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
